// ===== rtl/fds_pkg.sv =====
// Package with the shared types and constants of the feeder door sequencer.
`default_nettype none

package fds_pkg;

   typedef enum logic [2:0] {
      PH_CLOSED   = 3'd0,
      PH_OPENING  = 3'd1,
      PH_OPEN     = 3'd2,
      PH_ALARMING = 3'd3,
      PH_CLOSING  = 3'd4
   } phase_type;

   localparam logic [1:0] AUTO_OFF      = 2'd0;
   localparam logic [1:0] AUTO_INTERVAL = 2'd1;
   localparam logic [1:0] AUTO_DAILY    = 2'd2;

   localparam logic [2:0] REG_OPEN_ANGLE    = 3'd0;
   localparam logic [2:0] REG_CLOSED_ANGLE  = 3'd1;
   localparam logic [2:0] REG_STEP_PERIOD   = 3'd2;
   localparam logic [2:0] REG_DOOR_OPEN_MS  = 3'd3;
   localparam logic [2:0] REG_ALARM_MS      = 3'd4;
   localparam logic [2:0] REG_FEED_INTERVAL = 3'd5;
   localparam logic [2:0] REG_AUTO_MODE     = 3'd6;
   localparam logic [2:0] REG_SCHEDULE_MIN  = 3'd7;

   localparam logic [7:0]  RST_OPEN_ANGLE    = 8'd90;
   localparam logic [7:0]  RST_CLOSED_ANGLE  = 8'd0;
   localparam logic [15:0] RST_STEP_PERIOD   = 16'd15;
   localparam logic [31:0] RST_DOOR_OPEN_MS  = 32'd10000;
   localparam logic [31:0] RST_ALARM_MS      = 32'd3000;
   localparam logic [31:0] RST_FEED_INTERVAL = 32'd3600000;
   localparam logic [1:0]  RST_AUTO_MODE     = AUTO_OFF;
   localparam logic [10:0] RST_SCHEDULE_MIN  = 11'd480;

   typedef struct packed {
      logic        clock_valid;
      logic [10:0] clock_minute;
      logic        soft_close;
      logic        soft_open;
      logic        close_button;
      logic        open_button;
   } req_item_type;

   typedef struct packed {
      logic [15:0] feeds_done;
      logic        closed_pulse;
      logic        opened_pulse;
      logic        door_is_open;
      logic [2:0]  door_phase;
      logic [7:0]  servo_angle;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0]  open_angle;
      logic [7:0]  closed_angle;
      logic [31:0] open_hold_ms;
      logic [31:0] alarm_ms;
      logic [31:0] feed_interval_ms;
      logic [1:0]  auto_mode;
      logic [10:0] schedule_minute;
   } seq_cfg_type;

   function automatic logic [15:0] age16(input logic [15:0] v);
      age16 = (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/feeder_door_sequencer_top.sv =====
// Top level of the feeder door sequencer with its stream and register ports.
//
//   Port group   Direction  Payload
//   req_*        in         one millisecond tick item (buttons, requests, clock)
//   rsp_*        out        one status item per tick (angle, phase, pulses, count)
//   csr_*        in         register writes, index 0 to 7
//
// An accepted item sits in the input register while the update logic works on it,
// and its result is then captured in the output register. While the output is not
// stalled, one item is taken per cycle, a rate set by the state update between them.
// Synchronous reset restores each register but the item data to its documented value.
// When the result is not taken, the input register holds one more item and stops.
`default_nettype none

module feeder_door_sequencer_top #(
   parameter int DEBOUNCE_MS = 200,
   parameter int TIMER_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // open_button, close_button, soft_open, soft_close, clock_minute, clock_valid
   input  wire logic [15:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // servo_angle, door_phase, door_is_open, opened_pulse, closed_pulse,
   // feeds_done, two zero bits
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);
   import fds_pkg::*;

   logic [7:0]   open_angle_ff, closed_angle_ff;
   logic [15:0]  step_period_ff;
   logic [31:0]  door_open_ff, alarm_ff, interval_ff, hold_ff, hold_in;
   logic [1:0]   auto_mode_ff;
   logic [10:0]  schedule_ff;

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   logic         advance;
   logic [7:0]   angle_goal;
   logic [7:0]   angle_next;
   seq_cfg_type  seq_cfg;
   rsp_item_type result;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_angle_ff   <= RST_OPEN_ANGLE;
         closed_angle_ff <= RST_CLOSED_ANGLE;
         step_period_ff  <= RST_STEP_PERIOD;
         door_open_ff    <= RST_DOOR_OPEN_MS;
         alarm_ff        <= RST_ALARM_MS;
         interval_ff     <= RST_FEED_INTERVAL;
         auto_mode_ff    <= RST_AUTO_MODE;
         schedule_ff     <= RST_SCHEDULE_MIN;
      end else if (csr_we) begin
         case (csr_index)
            REG_OPEN_ANGLE:    open_angle_ff   <= csr_wdata[7:0];
            REG_CLOSED_ANGLE:  closed_angle_ff <= csr_wdata[7:0];
            REG_STEP_PERIOD:   step_period_ff  <= csr_wdata[15:0];
            REG_DOOR_OPEN_MS:  door_open_ff    <= csr_wdata;
            REG_ALARM_MS:      alarm_ff        <= csr_wdata;
            REG_FEED_INTERVAL: interval_ff     <= csr_wdata;
            REG_AUTO_MODE:     auto_mode_ff    <= csr_wdata[1:0];
            REG_SCHEDULE_MIN:  schedule_ff     <= csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   // The open phase lasts the open time minus the alarm time, never below zero.
   always_comb begin
      hold_in = hold_ff;
      if (csr_we && (csr_index == REG_DOOR_OPEN_MS)) begin
         hold_in = (csr_wdata > alarm_ff) ? (csr_wdata - alarm_ff) : '0;
      end else if (csr_we && (csr_index == REG_ALARM_MS)) begin
         hold_in = (door_open_ff > csr_wdata) ? (door_open_ff - csr_wdata) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= RST_DOOR_OPEN_MS - RST_ALARM_MS;
      end else begin
         hold_ff <= hold_in;
      end
   end

   always_comb begin
      seq_cfg.open_angle       = open_angle_ff;
      seq_cfg.closed_angle     = closed_angle_ff;
      seq_cfg.open_hold_ms     = hold_ff;
      seq_cfg.alarm_ms         = alarm_ff;
      seq_cfg.feed_interval_ms = interval_ff;
      seq_cfg.auto_mode        = auto_mode_ff;
      seq_cfg.schedule_minute  = schedule_ff;
   end

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_tdata;
      end
   end

   fds_servo u_servo (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .angle_goal     (angle_goal),
      .step_period_ms (step_period_ff),
      .angle_next     (angle_next)
   );

   fds_seq #(
      .DEBOUNCE_MS (DEBOUNCE_MS),
      .TIMER_BITS  (TIMER_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item       (in_item_ff),
      .cfg        (seq_cfg),
      .angle_next (angle_next),
      .angle_goal (angle_goal),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_item_ff};

endmodule

`default_nettype wire

// ===== rtl/fds_servo.sv =====
// Servo slew unit: angle register and step period timer.
`default_nettype none

module fds_servo (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        advance,
   input  wire logic [7:0]  angle_goal,
   input  wire logic [15:0] step_period_ms,
   output logic [7:0]       angle_next
);
   import fds_pkg::*;

   logic [7:0]  angle_now_ff;
   logic [7:0]  angle_now_in;
   logic [15:0] step_elapsed_ff;
   logic [15:0] step_elapsed_in;
   logic [15:0] step_aged;

   always_comb begin
      step_aged       = age16(step_elapsed_ff);
      angle_now_in    = angle_now_ff;
      step_elapsed_in = step_aged;
      if ((angle_now_ff != angle_goal) && (step_aged >= step_period_ms)) begin
         step_elapsed_in = '0;
         if (angle_now_ff < angle_goal) begin
            angle_now_in = angle_now_ff + 8'd1;
         end else begin
            angle_now_in = angle_now_ff - 8'd1;
         end
      end
   end

   assign angle_next = angle_now_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_now_ff    <= RST_CLOSED_ANGLE;
         step_elapsed_ff <= '0;
      end else if (advance) begin
         angle_now_ff    <= angle_now_in;
         step_elapsed_ff <= step_elapsed_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fds_seq.sv =====
// Door sequence, feed timers, debounce timers and request handling.
`default_nettype none

module fds_seq #(
   parameter int DEBOUNCE_MS = 200,
   parameter int TIMER_BITS  = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire fds_pkg::req_item_type item,
   input  wire fds_pkg::seq_cfg_type  cfg,
   input  wire logic [7:0]           angle_next,
   output logic [7:0]                angle_goal,
   output fds_pkg::rsp_item_type     result
);
   import fds_pkg::*;

   localparam logic [15:0] DebounceLimit = 16'(DEBOUNCE_MS);

   phase_type             phase_ff, phase_in;
   logic [7:0]            goal_ff, goal_in;
   logic [TIMER_BITS-1:0] phase_elapsed_ff, phase_elapsed_in;
   logic [TIMER_BITS-1:0] feed_elapsed_ff, feed_elapsed_in;
   logic [15:0]           open_db_ff, open_db_in;
   logic [15:0]           close_db_ff, close_db_in;
   logic                  fired_ff, fired_in;
   logic [15:0]           total_ff, total_in;
   logic                  opened, closed, in_min;

   always_comb begin
      phase_in         = phase_ff;
      goal_in          = goal_ff;
      phase_elapsed_in = (phase_elapsed_ff == '1) ? phase_elapsed_ff
                                                   : phase_elapsed_ff + TIMER_BITS'(1);
      feed_elapsed_in  = (feed_elapsed_ff == '1) ? feed_elapsed_ff
                                                  : feed_elapsed_ff + TIMER_BITS'(1);
      open_db_in       = age16(open_db_ff);
      close_db_in      = age16(close_db_ff);
      fired_in         = fired_ff;
      total_in         = total_ff;
      opened           = 1'b0;
      closed           = 1'b0;
      in_min           = (item.clock_minute == cfg.schedule_minute);

      case (phase_ff)
         PH_OPENING: begin
            if (angle_next == goal_ff) begin
               phase_in         = PH_OPEN;
               phase_elapsed_in = '0;
               opened           = 1'b1;
            end
         end
         PH_OPEN: begin
            if (32'(phase_elapsed_in) >= cfg.open_hold_ms) begin
               phase_in         = PH_ALARMING;
               phase_elapsed_in = '0;
            end
         end
         PH_ALARMING: begin
            if (32'(phase_elapsed_in) >= cfg.alarm_ms) begin
               phase_in = PH_CLOSING;
               goal_in  = cfg.closed_angle;
            end
         end
         PH_CLOSING: begin
            if (angle_next == goal_ff) begin
               phase_in        = PH_CLOSED;
               feed_elapsed_in = '0;
               total_in        = total_ff + 16'd1;
               closed          = 1'b1;
            end
         end
         PH_CLOSED: begin
            if (cfg.auto_mode == AUTO_DAILY) begin
               if (item.clock_valid) begin
                  if (in_min && !fired_ff) begin
                     fired_in = 1'b1;
                     phase_in = PH_OPENING;
                     goal_in  = cfg.open_angle;
                  end else if (!in_min) begin
                     fired_in = 1'b0;
                  end
               end
            end else if (cfg.auto_mode == AUTO_INTERVAL) begin
               if (32'(feed_elapsed_in) >= cfg.feed_interval_ms) begin
                  phase_in = PH_OPENING;
                  goal_in  = cfg.open_angle;
               end
            end
         end
         default: begin
         end
      endcase

      if (item.open_button && (open_db_in > DebounceLimit)) begin
         open_db_in = '0;
         if (phase_in == PH_CLOSED) begin
            phase_in = PH_OPENING;
            goal_in  = cfg.open_angle;
         end
      end
      if (item.close_button && (close_db_in > DebounceLimit)) begin
         close_db_in = '0;
         if ((phase_in != PH_CLOSED) && (phase_in != PH_CLOSING)) begin
            phase_in = PH_CLOSING;
            goal_in  = cfg.closed_angle;
         end
      end
      if (item.soft_open && (phase_in == PH_CLOSED)) begin
         phase_in = PH_OPENING;
         goal_in  = cfg.open_angle;
      end
      if (item.soft_close && (phase_in != PH_CLOSED) && (phase_in != PH_CLOSING)) begin
         phase_in = PH_CLOSING;
         goal_in  = cfg.closed_angle;
      end

      result.servo_angle  = angle_next;
      result.door_phase   = phase_in;
      result.door_is_open = (phase_in == PH_OPEN) || (phase_in == PH_ALARMING);
      result.opened_pulse = opened;
      result.closed_pulse = closed;
      result.feeds_done   = total_in;
   end

   assign angle_goal = goal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_CLOSED;
         goal_ff          <= RST_CLOSED_ANGLE;
         phase_elapsed_ff <= '0;
         feed_elapsed_ff  <= '0;
         open_db_ff       <= '0;
         close_db_ff      <= '0;
         fired_ff         <= 1'b0;
         total_ff         <= '0;
      end else if (advance) begin
         phase_ff         <= phase_in;
         goal_ff          <= goal_in;
         phase_elapsed_ff <= phase_elapsed_in;
         feed_elapsed_ff  <= feed_elapsed_in;
         open_db_ff       <= open_db_in;
         close_db_ff      <= close_db_in;
         fired_ff         <= fired_in;
         total_ff         <= total_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/fds_checker.sv =====
// Port-level checks of the feeder door sequencer and their binding.
`default_nettype none

module fds_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [15:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        csr_we,
   input wire logic [2:0]  csr_index,
   input wire logic [31:0] csr_wdata
);
   import fds_pkg::*;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result item changed");

   a_open_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[11] ==
         ((rsp_tdata[10:8] == PH_OPEN) || (rsp_tdata[10:8] == PH_ALARMING))))
      else $error("door open flag disagrees with phase");

   a_opened_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[12] |-> (rsp_tdata[10:8] == PH_OPEN)
         || (rsp_tdata[10:8] == PH_CLOSING))
      else $error("opened pulse outside open or closing phase");

   a_closed_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[13] |-> !rsp_tdata[12] && !rsp_tdata[11])
      else $error("closed pulse with door reported open");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result item valid right after reset");

endmodule

bind feeder_door_sequencer_top fds_checker u_fds_checker (.*);

`default_nettype wire
